/* design/tsd_pkg.sv */
// Shared types and constants of the telnet stream deframer.
`default_nettype none
package tsd_pkg;

  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;
  localparam logic [7:0] B_WILL = 8'd251;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEFAULT_WIDTH  = 3'd0,
    REG_DEFAULT_HEIGHT = 3'd1,
    REG_NAWS_OPTION    = 3'd2,
    REG_TTYPE_OPTION   = 3'd3,
    REG_CHARSET_OPTION = 3'd4,
    REG_COMPRESS_A     = 3'd5,
    REG_COMPRESS_B     = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_PLAIN  = 3'd0,
    PH_IAC    = 3'd1,
    PH_NEG    = 3'd2,
    PH_OPT    = 3'd3,
    PH_SUB    = 3'd4,
    PH_SUBIAC = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    OP_DATA     = 3'd0,
    OP_CMD      = 3'd1,
    OP_NEG      = 3'd2,
    OP_SUBSTART = 3'd3,
    OP_SUBDATA  = 3'd4,
    OP_SUBPAIR  = 3'd5,
    OP_SUBEND   = 3'd6
  } op_kind_t;

  localparam logic [2:0] TK_DATA     = 3'd0;
  localparam logic [2:0] TK_CMD      = 3'd1;
  localparam logic [2:0] TK_NEG      = 3'd2;
  localparam logic [2:0] TK_SUBSTART = 3'd3;
  localparam logic [2:0] TK_SUBDATA  = 3'd4;
  localparam logic [2:0] TK_SUBEND   = 3'd5;

  localparam logic [2:0] SC_GENERIC  = 3'd0;
  localparam logic [2:0] SC_NAWS     = 3'd1;
  localparam logic [2:0] SC_COMPRESS = 3'd2;
  localparam logic [2:0] SC_TTYPE    = 3'd3;
  localparam logic [2:0] SC_CHARSET  = 3'd4;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_MISSING = 2'd1;
  localparam logic [1:0] ERR_SEND    = 2'd2;
  localparam logic [1:0] ERR_UNKNOWN = 2'd3;

  localparam logic [7:0] TT_IS   = 8'd0;
  localparam logic [7:0] TT_SEND = 8'd1;

  localparam logic [2:0] HEAD_BYTES = 3'd4;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] value;
    logic [1:0] verb;
    logic [7:0] opt;
  } op_t;

  typedef struct packed {
    logic [15:0] default_width;
    logic [15:0] default_height;
    logic [7:0]  naws_option;
    logic [7:0]  ttype_option;
    logic [7:0]  charset_option;
    logic [7:0]  compress_option_a;
    logic [7:0]  compress_option_b;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [7:0]  byte_value;
    logic [1:0]  verb;
    logic [7:0]  option_code;
    logic [2:0]  sub_class;
    logic [1:0]  error_code;
    logic [15:0] win_width;
    logic [15:0] win_height;
    logic        last;
  } token_t;

endpackage
`default_nettype wire

/* design/tsd_front.sv */
// Front end: telnet byte parser that turns taken words into queued operations.
`default_nettype none
module tsd_front (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_take,
  input  wire logic [7:0] rx_byte,
  output tsd_pkg::op_t    op,
  output logic            op_push
);

  tsd_pkg::phase_t phase, phase_next;
  logic [1:0] held_verb;
  logic [7:0] sub_option;
  logic       op_emit;

  always_comb begin
    phase_next = phase;
    case (phase)
      tsd_pkg::PH_PLAIN: begin
        if (rx_byte == tsd_pkg::B_IAC) phase_next = tsd_pkg::PH_IAC;
      end
      tsd_pkg::PH_IAC: begin
        if (rx_byte == tsd_pkg::B_IAC) phase_next = tsd_pkg::PH_PLAIN;
        else if (rx_byte >= tsd_pkg::B_WILL) phase_next = tsd_pkg::PH_NEG;
        else if (rx_byte == tsd_pkg::B_SB) phase_next = tsd_pkg::PH_OPT;
        else phase_next = tsd_pkg::PH_PLAIN;
      end
      tsd_pkg::PH_NEG: phase_next = tsd_pkg::PH_PLAIN;
      tsd_pkg::PH_OPT: phase_next = tsd_pkg::PH_SUB;
      tsd_pkg::PH_SUB: begin
        if (rx_byte == tsd_pkg::B_IAC) phase_next = tsd_pkg::PH_SUBIAC;
      end
      tsd_pkg::PH_SUBIAC: begin
        if (rx_byte == tsd_pkg::B_SE) phase_next = tsd_pkg::PH_PLAIN;
        else phase_next = tsd_pkg::PH_SUB;
      end
      default: phase_next = tsd_pkg::PH_PLAIN;
    endcase
  end

  always_comb begin
    op_emit  = 1'b0;
    op.kind  = tsd_pkg::OP_DATA;
    op.value = rx_byte;
    op.verb  = 2'd0;
    op.opt   = sub_option;
    case (phase)
      tsd_pkg::PH_PLAIN: begin
        op_emit = (rx_byte != tsd_pkg::B_IAC);
      end
      tsd_pkg::PH_IAC: begin
        if (rx_byte == tsd_pkg::B_IAC) begin
          op_emit = 1'b1;
        end else if (rx_byte < tsd_pkg::B_WILL && rx_byte != tsd_pkg::B_SB) begin
          op_emit = 1'b1;
          op.kind = tsd_pkg::OP_CMD;
        end
      end
      tsd_pkg::PH_NEG: begin
        op_emit = 1'b1;
        op.kind = tsd_pkg::OP_NEG;
        op.verb = held_verb;
        op.opt  = rx_byte;
      end
      tsd_pkg::PH_OPT: begin
        op_emit = 1'b1;
        op.kind = tsd_pkg::OP_SUBSTART;
        op.opt  = rx_byte;
      end
      tsd_pkg::PH_SUB: begin
        op_emit = (rx_byte != tsd_pkg::B_IAC);
        op.kind = tsd_pkg::OP_SUBDATA;
      end
      tsd_pkg::PH_SUBIAC: begin
        op_emit = 1'b1;
        if (rx_byte == tsd_pkg::B_SE) op.kind = tsd_pkg::OP_SUBEND;
        else if (rx_byte == tsd_pkg::B_IAC) op.kind = tsd_pkg::OP_SUBDATA;
        else op.kind = tsd_pkg::OP_SUBPAIR;
      end
      default: op_emit = 1'b0;
    endcase
  end

  assign op_push = in_take && op_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= tsd_pkg::PH_PLAIN;
      held_verb  <= 2'd0;
      sub_option <= 8'd0;
    end else if (in_take) begin
      phase <= phase_next;
      if (phase == tsd_pkg::PH_IAC && rx_byte >= tsd_pkg::B_WILL) begin
        held_verb <= 2'(rx_byte - tsd_pkg::B_WILL);
      end
      if (phase == tsd_pkg::PH_OPT) sub_option <= rx_byte;
    end
  end

endmodule
`default_nettype wire

/* design/tsd_opq.sv */
// Small operation queue between the parser and the token builder.
`default_nettype none
module tsd_opq #(
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  wire tsd_pkg::op_t wr_op,
  input  wire logic         rd_en,
  output tsd_pkg::op_t      rd_op,
  output logic              q_valid,
  output logic              q_full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tsd_pkg::op_t mem [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;
  logic do_wr, do_rd;

  assign q_valid = (count != '0);
  assign q_full  = (count == CNT_W'(DEPTH));
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && q_valid;
  assign rd_op   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wptr] <= wr_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (do_rd) rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/tsd_back.sv */
// Back end: executes queued operations, tracks subnegotiation data, builds tokens.
`default_nettype none
module tsd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tsd_pkg::cfg_t cfg,
  input  wire tsd_pkg::op_t  op,
  input  wire logic          op_valid,
  output logic               op_pop,
  input  wire logic          tok_take,
  output logic               tok_valid,
  output tsd_pkg::token_t    tok
);

  logic [2:0]  sub_count;
  logic [31:0] sub_head;
  logic        second;
  logic        can_load, fire;
  logic        take_en;
  logic [7:0]  take_byte;
  logic [7:0]  first;
  tsd_pkg::token_t tok_next;

  assign can_load = !tok_valid || tok_take;
  assign fire     = op_valid && can_load;
  assign op_pop   = fire && !(op.kind == tsd_pkg::OP_SUBPAIR && !second);

  always_comb begin
    case (sub_count)
      3'd1:    first = sub_head[7:0];
      3'd2:    first = sub_head[15:8];
      3'd3:    first = sub_head[23:16];
      3'd4:    first = sub_head[31:24];
      default: first = 8'd0;
    endcase
  end

  always_comb begin
    tok_next   = '0;
    tok_next.last = 1'b1;
    take_en    = 1'b0;
    take_byte  = op.value;
    case (op.kind)
      tsd_pkg::OP_DATA: begin
        tok_next.token_kind = tsd_pkg::TK_DATA;
        tok_next.byte_value = op.value;
      end
      tsd_pkg::OP_CMD: begin
        tok_next.token_kind = tsd_pkg::TK_CMD;
        tok_next.byte_value = op.value;
      end
      tsd_pkg::OP_NEG: begin
        tok_next.token_kind  = tsd_pkg::TK_NEG;
        tok_next.verb        = op.verb;
        tok_next.option_code = op.opt;
      end
      tsd_pkg::OP_SUBSTART: begin
        tok_next.token_kind  = tsd_pkg::TK_SUBSTART;
        tok_next.option_code = op.opt;
      end
      tsd_pkg::OP_SUBDATA: begin
        tok_next.token_kind  = tsd_pkg::TK_SUBDATA;
        tok_next.byte_value  = op.value;
        tok_next.option_code = op.opt;
        take_en = 1'b1;
      end
      tsd_pkg::OP_SUBPAIR: begin
        tok_next.token_kind  = tsd_pkg::TK_SUBDATA;
        tok_next.option_code = op.opt;
        take_en = 1'b1;
        if (second) begin
          tok_next.byte_value = op.value;
        end else begin
          tok_next.byte_value = tsd_pkg::B_IAC;
          tok_next.last       = 1'b0;
          take_byte           = tsd_pkg::B_IAC;
        end
      end
      tsd_pkg::OP_SUBEND: begin
        tok_next.token_kind  = tsd_pkg::TK_SUBEND;
        tok_next.option_code = op.opt;
        if (op.opt == cfg.naws_option) begin
          tok_next.sub_class = tsd_pkg::SC_NAWS;
          if (sub_count >= tsd_pkg::HEAD_BYTES) begin
            tok_next.win_width  = sub_head[31:16];
            tok_next.win_height = sub_head[15:0];
          end else begin
            tok_next.win_width  = cfg.default_width;
            tok_next.win_height = cfg.default_height;
          end
        end else if (op.opt == cfg.compress_option_a || op.opt == cfg.compress_option_b) begin
          tok_next.sub_class = tsd_pkg::SC_COMPRESS;
        end else if (op.opt == cfg.ttype_option) begin
          tok_next.sub_class = tsd_pkg::SC_TTYPE;
          if (sub_count == 3'd0) tok_next.error_code = tsd_pkg::ERR_MISSING;
          else if (first == tsd_pkg::TT_IS) tok_next.error_code = tsd_pkg::ERR_NONE;
          else if (first == tsd_pkg::TT_SEND) tok_next.error_code = tsd_pkg::ERR_SEND;
          else tok_next.error_code = tsd_pkg::ERR_UNKNOWN;
        end else if (op.opt == cfg.charset_option) begin
          tok_next.sub_class = tsd_pkg::SC_CHARSET;
          if (sub_count == 3'd0) tok_next.error_code = tsd_pkg::ERR_MISSING;
          else tok_next.byte_value = first;
        end else begin
          tok_next.sub_class = tsd_pkg::SC_GENERIC;
        end
      end
      default: tok_next.token_kind = tsd_pkg::TK_DATA;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire) tok <= tok_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
      second    <= 1'b0;
      sub_count <= 3'd0;
      sub_head  <= 32'd0;
    end else begin
      if (fire) tok_valid <= 1'b1;
      else if (tok_take) tok_valid <= 1'b0;
      if (fire) begin
        second <= (op.kind == tsd_pkg::OP_SUBPAIR) && !second;
        if (op.kind == tsd_pkg::OP_SUBSTART) begin
          sub_count <= 3'd0;
          sub_head  <= 32'd0;
        end else if (take_en && sub_count < tsd_pkg::HEAD_BYTES) begin
          sub_head  <= {sub_head[23:0], take_byte};
          sub_count <= sub_count + 3'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* design/telnet_stream_deframer.sv */
// Top level of the telnet stream deframer: config registers, parser, queue, token builder.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  input   | push / full            | rx_byte
//  result  | empty / pop            | token_kind byte_value verb option_code
//          |                        | sub_class error_code win_width win_height last
//  config  | cfg_valid / cfg_ready  | cfg_index cfg_data
//
// One word per cycle enters while full is low; the parser settles each word in the cycle
// it is taken. A word that yields two tokens (IAC plus another byte inside a
// subnegotiation) needs the builder for both; the queue absorbs that, so while pop keeps
// up the rate is one word per cycle apart from those pairs; ops are registered in the
// queue, tokens in the token register; full rises once the queue fills while pop is held
// low. Synchronous reset clears parser, queue and output state; cfg_ready is always high.
`default_nettype none
module telnet_stream_deframer #(
  parameter int OPQ_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  rx_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       token_kind,
  output logic [7:0]       byte_value,
  output logic [1:0]       verb,
  output logic [7:0]       option_code,
  output logic [2:0]       sub_class,
  output logic [1:0]       error_code,
  output logic [15:0]      win_width,
  output logic [15:0]      win_height,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [tsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tsd_pkg::CFG_DAT_W-1:0] cfg_data
);

  tsd_pkg::cfg_t   cfg;
  tsd_pkg::op_t    f_op, q_op;
  tsd_pkg::token_t tok;
  logic f_push, q_valid, q_full, q_pop, tok_valid, in_take, tok_take;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign in_take   = push && !q_full;
  assign empty     = !tok_valid;
  assign tok_take  = pop && tok_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.default_width     <= 16'd80;
      cfg.default_height    <= 16'd24;
      cfg.naws_option       <= 8'd31;
      cfg.ttype_option      <= 8'd24;
      cfg.charset_option    <= 8'd42;
      cfg.compress_option_a <= 8'd86;
      cfg.compress_option_b <= 8'd87;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tsd_pkg::REG_DEFAULT_WIDTH:  cfg.default_width     <= cfg_data;
        tsd_pkg::REG_DEFAULT_HEIGHT: cfg.default_height    <= cfg_data;
        tsd_pkg::REG_NAWS_OPTION:    cfg.naws_option       <= cfg_data[7:0];
        tsd_pkg::REG_TTYPE_OPTION:   cfg.ttype_option      <= cfg_data[7:0];
        tsd_pkg::REG_CHARSET_OPTION: cfg.charset_option    <= cfg_data[7:0];
        tsd_pkg::REG_COMPRESS_A:     cfg.compress_option_a <= cfg_data[7:0];
        tsd_pkg::REG_COMPRESS_B:     cfg.compress_option_b <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  tsd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_take (in_take),
    .rx_byte (rx_byte),
    .op      (f_op),
    .op_push (f_push)
  );

  tsd_opq #(.DEPTH(OPQ_DEPTH)) u_opq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_push),
    .wr_op   (f_op),
    .rd_en   (q_pop),
    .rd_op   (q_op),
    .q_valid (q_valid),
    .q_full  (q_full)
  );

  tsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .op        (q_op),
    .op_valid  (q_valid),
    .op_pop    (q_pop),
    .tok_take  (tok_take),
    .tok_valid (tok_valid),
    .tok       (tok)
  );

  assign token_kind  = tok.token_kind;
  assign byte_value  = tok.byte_value;
  assign verb        = tok.verb;
  assign option_code = tok.option_code;
  assign sub_class   = tok.sub_class;
  assign error_code  = tok.error_code;
  assign win_width   = tok.win_width;
  assign win_height  = tok.win_height;
  assign last        = tok.last;

endmodule
`default_nettype wire
